// ----- rtl/iptrie_pkg.sv -----
// Shared types and constants for the IPv6 binary trie longest-prefix match block.
// Used by iptrie_walker, ipv6_binary_trie_lpm and the testbench; no dependencies.
package iptrie_pkg;

    localparam int ADDR_BITS = 128;
    localparam int LEN_W     = 8;
    localparam int HOP_W     = 8;
    localparam int STATUS_W  = 2;

    // Longest prefix an insert can carry
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_BITS);

    // Request kinds (s_tuser)
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // One result as handed from the walker to the output register
    typedef struct packed {
        logic [HOP_W-1:0]    hop;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

// ----- rtl/ipv6_binary_trie_lpm.sv -----
// IPv6 binary trie longest-prefix match: stream ports, output register.
// Instantiates iptrie_walker; uses iptrie_pkg.
//
// Usage:
//   Requests enter on the s_ channel (tvalid/tready). s_tuser selects a
//   lookup (0) or a prefix insert (1); s_tdata carries the 128-bit address,
//   prefix length and next hop. Every request gives exactly one result on
//   the m_ channel: status (0 done or match, 1 no match, 2 node pool full)
//   and the matched next hop.
//   The walk visits one trie level per cycle: one node memory read per
//   address bit. A lookup walks down to depth 128 at most, an insert of
//   length L down to depth L at most; a zero-length insert goes straight to
//   done without a walk. The result then moves into the output register.
//   s_tready is high only while the walker is idle; a new request is taken
//   while a previous result still waits in the output register.
//   If m_tready stays low, the finished result is held in the walker until
//   the output register frees up, and no further request is taken.
//   Reset leaves the trie holding an empty root only; no clearing pass.
module ipv6_binary_trie_lpm
    import iptrie_pkg::*;
#(
    parameter int NODE_COUNT = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // addr_word0, addr_word1, addr_word2, addr_word3,
                                   // prefix_len, hop_in
    input  logic [0:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata   // status, hop_out, zero pad
);

    logic                 walk_idle;
    logic                 walk_start;
    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;
    logic [ADDR_BITS-1:0] req_addr;
    logic                 m_tvalid_reg;
    res_t                 m_res_reg;

    // Address word 0 holds the most significant bits
    assign req_addr   = {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]};
    assign s_tready   = walk_idle;
    assign walk_start = s_tvalid && walk_idle;

    iptrie_walker #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .idle       (walk_idle),
        .start      (walk_start),
        .kind       (s_tuser[0]),
        .addr       (req_addr),
        .prefix_len (s_tdata[135:128]),
        .hop_in     (s_tdata[143:136]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg.hop, m_res_reg.status};

endmodule

// ----- rtl/iptrie_node_ram.sv -----
// Trie node memory: one write port, one read port with registered read data.
// Standalone; no package needed.
module iptrie_node_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 33
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/iptrie_walker.sv -----
// Trie walk sequencer: one level per cycle through a shared node step unit.
// Holds the root node and pool counter; instantiates iptrie_node_ram; uses iptrie_pkg.
module iptrie_walker
    import iptrie_pkg::*;
#(
    parameter int NODE_COUNT = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    output logic                 idle,
    input  logic                 start,
    input  logic                 kind,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [LEN_W-1:0]     prefix_len,
    input  logic [HOP_W-1:0]     hop_in,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int NODE_W = 2 * IDX_W + 1 + HOP_W;
    localparam logic [CNT_W-1:0] POOL_SIZE = CNT_W'(NODE_COUNT);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    // Where the current node comes from
    localparam logic [1:0] SRC_ROOT = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_NEW  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           src_reg, src_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]     depth_reg, depth_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [HOP_W-1:0]     hop_in_reg, hop_in_next;
    logic [IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    logic                 found_reg, found_next;
    logic [HOP_W-1:0]     best_reg, best_next;
    res_t                 res_reg, res_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [IDX_W-1:0]     root_left_reg, root_left_next;
    logic [IDX_W-1:0]     root_right_reg, root_right_next;
    logic                 root_has_reg, root_has_next;
    logic [HOP_W-1:0]     root_hop_reg, root_hop_next;

    // Current node view
    logic [IDX_W-1:0] cur_left, cur_right, cur_link, new_idx;
    logic             cur_has, cur_bit;
    logic [HOP_W-1:0] cur_hop;

    // Node write request (index 0 goes to the root registers)
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx, wr_left, wr_right;
    logic             wr_has;
    logic [HOP_W-1:0] wr_hop;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [NODE_W-1:0] rd_data;
    logic              lk_found;
    logic [HOP_W-1:0]  lk_best;
    logic [LEN_W-1:0]  len_sat;

    iptrie_node_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (NODE_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en && (wr_idx != '0)),
        .wr_addr (wr_idx),
        .wr_data ({wr_left, wr_right, wr_has, wr_hop}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Current node select
    always_comb begin
        case (src_reg)
            SRC_ROOT: begin
                cur_left  = root_left_reg;
                cur_right = root_right_reg;
                cur_has   = root_has_reg;
                cur_hop   = root_hop_reg;
            end
            SRC_MEM: begin
                {cur_left, cur_right, cur_has, cur_hop} = rd_data;
            end
            default: begin
                cur_left  = '0;
                cur_right = '0;
                cur_has   = 1'b0;
                cur_hop   = '0;
            end
        endcase
    end

    assign cur_bit  = addr_reg[ADDR_BITS-1];
    assign cur_link = cur_bit ? cur_right : cur_left;
    assign new_idx  = used_reg[IDX_W-1:0];
    assign lk_found = found_reg | cur_has;
    assign lk_best  = cur_has ? cur_hop : best_reg;
    assign len_sat  = (prefix_len > LEN_MAX) ? LEN_MAX : prefix_len;

    // Sequencer and node step
    always_comb begin
        state_next      = state_reg;
        src_next        = src_reg;
        addr_next       = addr_reg;
        depth_next      = depth_reg;
        len_next        = len_reg;
        hop_in_next     = hop_in_reg;
        cur_idx_next    = cur_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        res_next        = res_reg;
        used_next       = used_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        root_has_next   = root_has_reg;
        root_hop_next   = root_hop_reg;
        wr_en           = 1'b0;
        wr_idx          = cur_idx_reg;
        wr_left         = cur_left;
        wr_right        = cur_right;
        wr_has          = cur_has;
        wr_hop          = cur_hop;
        rd_en           = 1'b0;
        rd_addr         = cur_link;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    addr_next    = addr;
                    len_next     = len_sat;
                    hop_in_next  = hop_in;
                    depth_next   = '0;
                    src_next     = SRC_ROOT;
                    cur_idx_next = '0;
                    found_next   = 1'b0;
                    best_next    = '0;
                    res_next     = res_t'{hop: '0, status: STATUS_OK};
                    if (kind == KIND_LOOKUP) begin
                        state_next = ST_LOOKUP;
                    end else if (len_sat == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_LOOKUP: begin
                found_next = lk_found;
                best_next  = lk_best;
                if ((depth_reg == LEN_MAX) || (cur_link == '0)) begin
                    if (lk_found) begin
                        res_next = res_t'{hop: lk_best, status: STATUS_OK};
                    end else begin
                        res_next = res_t'{hop: '0, status: STATUS_NO_MATCH};
                    end
                    state_next = ST_DONE;
                end else begin
                    rd_en        = 1'b1;
                    cur_idx_next = cur_link;
                    src_next     = SRC_MEM;
                    depth_next   = depth_reg + LEN_W'(1);
                    addr_next    = {addr_reg[ADDR_BITS-2:0], 1'b0};
                end
            end
            ST_INSERT: begin
                if (depth_reg == len_reg) begin
                    // final node: keep an existing hop
                    wr_en      = 1'b1;
                    wr_has     = 1'b1;
                    wr_hop     = cur_has ? cur_hop : hop_in_reg;
                    res_next   = res_t'{hop: '0, status: STATUS_OK};
                    state_next = ST_DONE;
                end else if (cur_link != '0) begin
                    rd_en        = 1'b1;
                    cur_idx_next = cur_link;
                    src_next     = SRC_MEM;
                    depth_next   = depth_reg + LEN_W'(1);
                    addr_next    = {addr_reg[ADDR_BITS-2:0], 1'b0};
                end else if (used_reg >= POOL_SIZE) begin
                    // commit the node as is (a fresh node gets cleared here)
                    wr_en      = 1'b1;
                    res_next   = res_t'{hop: '0, status: STATUS_FULL};
                    state_next = ST_DONE;
                end else begin
                    // allocate child, link it from the current node
                    wr_en = 1'b1;
                    if (cur_bit) begin
                        wr_right = new_idx;
                    end else begin
                        wr_left = new_idx;
                    end
                    cur_idx_next = new_idx;
                    src_next     = SRC_NEW;
                    used_next    = used_reg + CNT_W'(1);
                    depth_next   = depth_reg + LEN_W'(1);
                    addr_next    = {addr_reg[ADDR_BITS-2:0], 1'b0};
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Root lives in registers
        if (wr_en && (wr_idx == '0)) begin
            root_left_next  = wr_left;
            root_right_next = wr_right;
            root_has_next   = wr_has;
            root_hop_next   = wr_hop;
        end
    end

    // Control state and root node
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= CNT_W'(1);
            root_left_reg  <= '0;
            root_right_reg <= '0;
            root_has_reg   <= 1'b0;
            root_hop_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            root_has_reg   <= root_has_next;
            root_hop_reg   <= root_hop_next;
        end
    end

    // Walk payload
    always_ff @(posedge aclk) begin
        src_reg     <= src_next;
        addr_reg    <= addr_next;
        depth_reg   <= depth_next;
        len_reg     <= len_next;
        hop_in_reg  <= hop_in_next;
        cur_idx_reg <= cur_idx_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        res_reg     <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

`ifndef SYNTHESIS
    // Pool counter stays within the node memory
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg >= CNT_W'(1)) && (used_reg <= POOL_SIZE))
        else $error("node pool counter out of range");

    // Writes only touch nodes already handed out
    a_wr_allocated: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ({1'b0, wr_idx} < {1'b0, used_reg}))
        else $error("node write beyond allocated pool");

    // A lookup never sees a freshly allocated node
    a_lookup_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP) |-> (src_reg != SRC_NEW))
        else $error("lookup walking an unwritten node");

    // An insert walk never passes its prefix length
    a_insert_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSERT) |-> (depth_reg <= len_reg))
        else $error("insert walked past prefix length");

    // Pool only grows during an insert
    a_alloc_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_next != used_reg) |-> (state_reg == ST_INSERT))
        else $error("node allocated outside insert");
`endif

endmodule

// ----- tb/tb_ipv6_binary_trie_lpm.sv -----
// Testbench for ipv6_binary_trie_lpm: a trie model in a scoreboard class predicts every
// lookup and insert result. Depends on iptrie_pkg and the ipv6_binary_trie_lpm RTL.
module tb_ipv6_binary_trie_lpm;
    import iptrie_pkg::*;

    localparam int TB_NODES     = 4096;
    localparam int RANDOM_ITEMS = 900;
    localparam int SETTLE       = 300;

    // Trie predictor and queue of expected results
    class lpm_scoreboard #(int NODES = 4096);
        int unsigned   left_link [NODES];
        int unsigned   right_link[NODES];
        bit            hop_set   [NODES];
        logic [7:0]    node_hop  [NODES];
        int unsigned   nodes_used;
        res_t          expected_results[$];
        int            error_count;

        function new();
            left_link[0]  = 0;
            right_link[0] = 0;
            hop_set[0]    = 0;
            node_hop[0]   = '0;
            nodes_used    = 1;
            error_count   = 0;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        // Walk the trie for one accepted request and queue its result
        function void note_request(logic kind, logic [127:0] addr, logic [7:0] len,
                                   logic [7:0] hop_in);
            res_t        r;
            int unsigned cur;
            int unsigned nxt;
            int unsigned depth_lim;
            bit          full;
            bit          found;
            r.status = STATUS_OK;
            r.hop    = '0;
            cur      = 0;
            if (kind == KIND_INSERT) begin
                // lengths past 128 saturate
                depth_lim = (len > LEN_MAX) ? ADDR_BITS : len;
                full = 0;
                for (int d = 0; d < depth_lim && !full; d++) begin
                    nxt = addr[127-d] ? right_link[cur] : left_link[cur];
                    if (nxt == 0) begin
                        if (nodes_used >= NODES) begin
                            full = 1;
                        end else begin
                            nxt = nodes_used;
                            left_link[nxt]  = 0;
                            right_link[nxt] = 0;
                            hop_set[nxt]    = 0;
                            node_hop[nxt]   = '0;
                            if (addr[127-d]) right_link[cur] = nxt;
                            else left_link[cur] = nxt;
                            nodes_used++;
                        end
                    end
                    if (!full) cur = nxt;
                end
                if (full) begin
                    r.status = STATUS_FULL;
                end else if (depth_lim != 0 && !hop_set[cur]) begin
                    // first hop stored at a node wins
                    hop_set[cur]  = 1;
                    node_hop[cur] = hop_in;
                end
            end else begin
                found = 0;
                for (int d = 0; d <= ADDR_BITS; d++) begin
                    if (hop_set[cur]) begin
                        found = 1;
                        r.hop = node_hop[cur];
                    end
                    if (d == ADDR_BITS) break;
                    cur = addr[127-d] ? right_link[cur] : left_link[cur];
                    if (cur == 0) break;
                end
                if (!found) r.status = STATUS_NO_MATCH;
            end
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            $display("ERROR at %0t: %s got 0x%02h expected 0x%02h", $time, what, got, want);
            error_count++;
        endtask

        // Compare one result against the oldest expectation
        task check_result(logic [15:0] data);
            res_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request pending", data[9:2], 8'h00);
                return;
            end
            want = expected_results.pop_front();
            if (data[1:0] !== want.status)
                report_mismatch("status", {6'd0, data[1:0]}, {6'd0, want.status});
            if (data[9:2] !== want.hop)
                report_mismatch("hop_out", data[9:2], want.hop);
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;   // addr_word0, addr_word1, addr_word2, addr_word3, prefix_len, hop_in
    logic [0:0]   s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;   // status, hop_out, zero pad

    bit           no_gaps;
    lpm_scoreboard #(TB_NODES) sb;

    ipv6_binary_trie_lpm #(.NODE_COUNT(TB_NODES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [127:0] rand_addr();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [127:0] prefix_mask(int unsigned bits);
        if (bits == 0) return '0;
        return ~128'd0 << (128 - bits);
    endfunction

    // Drive one request; entered and left at a falling edge
    task send_request(logic kind, logic [127:0] addr, logic [7:0] len, logic [7:0] hop);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = kind;
        s_tdata  = {hop, len, addr[31:0], addr[63:32], addr[95:64], addr[127:96]};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, addr, len, hop);
        @(negedge aclk);
    endtask

    // Hold off new requests until every result is back
    task wait_for_idle();
        s_tvalid = 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Result side: random stalls, check on every accepted result
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            @(negedge aclk);
        end
    end

    // Stimulus
    initial begin
        logic [127:0] prefixes[$];
        int unsigned  prefix_lens[$];
        logic [127:0] addr;
        logic [127:0] tail;
        logic [127:0] pat;
        logic [7:0]   len;
        logic [7:0]   hop;
        int unsigned  pick;
        int unsigned  how;
        int unsigned  k;
        sb       = new();
        no_gaps  = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_LOOKUP;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty trie, zero length, saturation, existing hops, hop value zero
        pat = 128'h3fff_1234_5678_9abc_0000_0000_0000_0000;
        send_request(KIND_LOOKUP, '0, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, '1, 8'hff, 8'hff);
        send_request(KIND_INSERT, '1, 8'd0, 8'h55);
        send_request(KIND_LOOKUP, '1, 8'd0, 8'h00);
        send_request(KIND_INSERT, 128'h1 << 127, 8'd1, 8'haa);
        send_request(KIND_INSERT, '1, 8'd128, 8'hff);
        send_request(KIND_INSERT, '1, 8'd200, 8'h11);
        send_request(KIND_INSERT, '0, 8'd255, 8'h01);
        send_request(KIND_INSERT, '0, 8'd128, 8'h02);
        send_request(KIND_INSERT, 128'h1 << 127, 8'd1, 8'h33);
        send_request(KIND_INSERT, pat, 8'd64, 8'h00);
        send_request(KIND_INSERT, pat, 8'd129, 8'h5a);
        send_request(KIND_LOOKUP, '1, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, ~128'h1, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, '0, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, 128'h1, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, 128'h1 << 127, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, ~(128'h1 << 127), 8'd0, 8'h00);
        send_request(KIND_LOOKUP, pat, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, pat ^ 128'h1, 8'd0, 8'h00);
        send_request(KIND_LOOKUP, pat ^ (128'h1 << 64), 8'd0, 8'h00);
        wait_for_idle();

        // Random: inserts and lookups mostly built on prefixes already stored
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps = (n >= 300 && n < 380) || (n >= 650 && n < 720);
            if (n == 450) wait_for_idle();
            pick = $urandom_range(0, 99);
            how  = $urandom_range(0, 99);
            tail = rand_addr();
            hop  = 8'($urandom);
            k    = (prefixes.size() > 0) ? $urandom_range(0, prefixes.size() - 1) : 0;
            if (pick < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) len = 8'd0;
                else if (pick < 12) len = 8'($urandom_range(129, 255));
                else if (pick < 50) len = 8'($urandom_range(1, 32));
                else len = 8'($urandom_range(1, 128));
                if (prefixes.size() == 0 || how < 40) begin
                    addr = tail;
                end else if (how < 80) begin
                    // extend or cut an existing prefix
                    addr = (prefixes[k] & prefix_mask(prefix_lens[k]))
                         | (tail & ~prefix_mask(prefix_lens[k]));
                end else begin
                    // same prefix again: stored hop must stay
                    addr = prefixes[k];
                    len  = 8'(prefix_lens[k]);
                end
                send_request(KIND_INSERT, addr, len, hop);
                if (len != 0) begin
                    prefixes.push_back(addr);
                    prefix_lens.push_back((len > LEN_MAX) ? ADDR_BITS : len);
                end
            end else begin
                if (prefixes.size() == 0 || how < 30) addr = tail;
                else addr = (prefixes[k] & prefix_mask(prefix_lens[k]))
                          | (tail & ~prefix_mask(prefix_lens[k]));
                send_request(KIND_LOOKUP, addr, 8'($urandom), hop);
            end
        end

        // Drain and let any stray result show up
        no_gaps = 1'b0;
        wait_for_idle();
        repeat (SETTLE) @(posedge aclk);
        if (sb.error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/iptrie_pkg.sv
rtl/iptrie_node_ram.sv
rtl/iptrie_walker.sv
rtl/ipv6_binary_trie_lpm.sv
tb/tb_ipv6_binary_trie_lpm.sv
